// ===== hw/rtl/oosf_pkg.sv =====
// ----------------------------------------------------------------------------
// oosf_pkg
// Types, constants and helpers shared by the start-session frame parser.
// ----------------------------------------------------------------------------
package oosf_pkg;

  // Frame layout
  localparam logic [5:0]  CNT_MAX     = 6'd63;
  localparam logic [5:0]  FRAME_LEN   = 6'd34;
  localparam logic [5:0]  MIN_LEN     = 6'd6;
  localparam logic [5:0]  SESS_LEN    = 6'd12;
  localparam logic [5:0]  MAGIC_LEN   = 6'd5;
  localparam logic [5:0]  POS_TYPE    = 6'd5;
  localparam logic [5:0]  POS_PLEN_LO = 6'd6;
  localparam logic [5:0]  POS_PLEN_HI = 6'd7;
  localparam logic [5:0]  POS_SESS    = 6'd8;
  localparam logic [5:0]  FIELD_BASE  = 6'd12;
  localparam int unsigned FIELD_DEPTH = 14;

  // Field byte slots, relative to FIELD_BASE
  localparam int unsigned F_CTRL  = 0;
  localparam int unsigned F_CTEE  = 2;
  localparam int unsigned F_CHAN  = 4;
  localparam int unsigned F_PREAM = 5;
  localparam int unsigned F_SLOT  = 6;
  localparam int unsigned F_BLOCK = 8;
  localparam int unsigned F_COUNT = 10;
  localparam int unsigned F_STS   = 12;
  localparam int unsigned F_KEY   = 13;

  // Protocol values
  localparam logic [7:0]  MAGIC_U     = 8'h55;
  localparam logic [7:0]  MAGIC_T     = 8'h54;
  localparam logic [7:0]  MAGIC_O     = 8'h4F;
  localparam logic [7:0]  MAGIC_B     = 8'h42;
  localparam logic [7:0]  VERSION     = 8'h01;
  localparam logic [7:0]  PROBE_BYTE  = 8'h01;
  localparam logic [7:0]  MSG_START   = 8'h02;
  localparam logic [7:0]  MSG_ACK     = 8'h82;
  localparam logic [7:0]  ACK_PLEN    = 8'h05;
  localparam logic [15:0] PLEN_EXPECT = 16'd26;
  localparam logic [7:0]  KEY_EXPECT  = 8'h08;

  // Acknowledge burst: 13 bytes, then the parameter item
  localparam int unsigned IDX_W     = 4;
  localparam logic [3:0]  ACK_LAST  = 4'd12;
  localparam logic [3:0]  PARAM_IDX = 4'd13;

  // Queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Result kinds
  localparam logic [1:0] KIND_BYTE   = 2'd0;
  localparam logic [1:0] KIND_PARAMS = 2'd1;
  localparam logic [1:0] KIND_NOREC  = 2'd2;

  // Acknowledge status
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_LEN   = 2'd1;
  localparam logic [1:0] ST_FIELD = 2'd2;

  typedef enum logic [1:0] {
    ACT_PROBE,
    ACT_NOREC,
    ACT_ACK
  } action_t;

  // Frame verdict handed from front to back
  typedef struct packed {
    action_t     action;
    logic [1:0]  status;
    logic [31:0] session;
    logic [15:0] ctrl_addr;
    logic [15:0] ctee_addr;
    logic [7:0]  channel;
    logic [7:0]  preamble;
    logic [15:0] slot;
    logic [15:0] block;
    logic [7:0]  slot_count;
    logic [7:0]  sts;
  } desc_t;

  // One result item
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  resp_byte;
    logic        run_last;
    logic [31:0] session_value;
    logic [15:0] dst_addr;
    logic [15:0] src_addr;
    logic [7:0]  channel;
    logic [7:0]  preamble;
    logic [15:0] slot_time;
    logic [15:0] block_time;
    logic [23:0] round_duration;
    logic [7:0]  sts_mode;
  } result_t;

  // Expected header byte at positions 0..4
  function automatic logic [7:0] magic_byte(input logic [2:0] pos);
    logic [7:0] v;
    v = VERSION;
    case (pos)
      3'd0:    v = MAGIC_U;
      3'd1:    v = MAGIC_T;
      3'd2:    v = MAGIC_O;
      3'd3:    v = MAGIC_B;
      default: v = VERSION;
    endcase
    return v;
  endfunction

  // Acknowledge byte at burst position idx
  function automatic logic [7:0] ack_byte(input logic [3:0] idx, input logic [1:0] status,
                                          input logic [31:0] session);
    logic [7:0] v;
    v = 8'h00;
    case (idx)
      4'd0:    v = MAGIC_U;
      4'd1:    v = MAGIC_T;
      4'd2:    v = MAGIC_O;
      4'd3:    v = MAGIC_B;
      4'd4:    v = VERSION;
      4'd5:    v = MSG_ACK;
      4'd6:    v = ACK_PLEN;
      4'd8:    v = {6'd0, status};
      4'd9:    v = session[7:0];
      4'd10:   v = session[15:8];
      4'd11:   v = session[23:16];
      4'd12:   v = session[31:24];
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/oosf_front.sv =====
// ----------------------------------------------------------------------------
// oosf_front
// Captures frame bytes as they arrive and judges the frame on its last byte.
// ----------------------------------------------------------------------------
module oosf_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       rx_byte,
  input  logic             frame_end,
  input  logic             q_full,
  output logic             q_push,
  output oosf_pkg::desc_t  q_desc
);

  logic [5:0]  byte_count;
  logic [7:0]  first_byte;
  logic        magic_ok;
  logic [7:0]  msg_type;
  logic [15:0] plen;
  logic [31:0] session_reg;
  logic [7:0]  field_bytes [oosf_pkg::FIELD_DEPTH];

  logic        accept;
  logic        clr;
  logic [5:0]  count_next;
  logic [7:0]  first_byte_next;
  logic        magic_ok_next;
  logic [7:0]  msg_type_next;
  logic [15:0] plen_next;
  logic [31:0] session_reg_next;
  logic [31:0] sess_eff;
  logic        is_probe;
  logic        is_norec;
  logic        bad_fields;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign clr      = (byte_count == '0);

  // Per-byte capture
  always_comb begin
    count_next = (byte_count == oosf_pkg::CNT_MAX) ? oosf_pkg::CNT_MAX : byte_count + 6'd1;
    first_byte_next = clr ? rx_byte : first_byte;
    magic_ok_next = (clr || magic_ok) &&
                    !(byte_count < oosf_pkg::MAGIC_LEN &&
                      rx_byte != oosf_pkg::magic_byte(byte_count[2:0]));
    msg_type_next = (byte_count == oosf_pkg::POS_TYPE) ? rx_byte :
                    (clr ? 8'h00 : msg_type);
    plen_next = clr ? 16'h0000 : plen;
    if (byte_count == oosf_pkg::POS_PLEN_LO) begin
      plen_next[7:0] = rx_byte;
    end
    if (byte_count == oosf_pkg::POS_PLEN_HI) begin
      plen_next[15:8] = rx_byte;
    end
    session_reg_next = clr ? 32'h0 : session_reg;
    for (int k = 0; k < 4; k++) begin
      if (byte_count == oosf_pkg::POS_SESS + 6'(k)) begin
        session_reg_next[8*k +: 8] = rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else if (accept) begin
      byte_count <= frame_end ? '0 : count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      first_byte  <= first_byte_next;
      magic_ok    <= magic_ok_next;
      msg_type    <= msg_type_next;
      plen        <= plen_next;
      session_reg <= session_reg_next;
      for (int i = 0; i < oosf_pkg::FIELD_DEPTH; i++) begin
        if (clr) begin
          field_bytes[i] <= 8'h00;
        end else if (byte_count == oosf_pkg::FIELD_BASE + 6'(i)) begin
          field_bytes[i] <= rx_byte;
        end
      end
    end
  end

  // Frame verdict, built on the final byte
  always_comb begin
    is_probe = (count_next == 6'd1) && (first_byte_next == oosf_pkg::PROBE_BYTE);
    is_norec = (count_next < oosf_pkg::MIN_LEN) || !magic_ok_next;
    sess_eff = (count_next >= oosf_pkg::SESS_LEN) ? session_reg_next : 32'h0;
    bad_fields = (sess_eff == 32'h0) ||
                 ({field_bytes[oosf_pkg::F_CTRL + 1], field_bytes[oosf_pkg::F_CTRL]} == '0) ||
                 ({field_bytes[oosf_pkg::F_CTEE + 1], field_bytes[oosf_pkg::F_CTEE]} == '0) ||
                 (field_bytes[oosf_pkg::F_KEY] != oosf_pkg::KEY_EXPECT);

    q_desc = '0;
    if (is_probe) begin
      q_desc.action = oosf_pkg::ACT_PROBE;
    end else if (is_norec) begin
      q_desc.action = oosf_pkg::ACT_NOREC;
    end else begin
      q_desc.action = oosf_pkg::ACT_ACK;
    end
    if (count_next != oosf_pkg::FRAME_LEN || plen != oosf_pkg::PLEN_EXPECT) begin
      q_desc.status = oosf_pkg::ST_LEN;
    end else if (bad_fields) begin
      q_desc.status = oosf_pkg::ST_FIELD;
    end else begin
      q_desc.status = oosf_pkg::ST_OK;
    end
    q_desc.session    = sess_eff;
    q_desc.ctrl_addr  = {field_bytes[oosf_pkg::F_CTRL + 1], field_bytes[oosf_pkg::F_CTRL]};
    q_desc.ctee_addr  = {field_bytes[oosf_pkg::F_CTEE + 1], field_bytes[oosf_pkg::F_CTEE]};
    q_desc.channel    = field_bytes[oosf_pkg::F_CHAN];
    q_desc.preamble   = field_bytes[oosf_pkg::F_PREAM];
    q_desc.slot       = {field_bytes[oosf_pkg::F_SLOT + 1], field_bytes[oosf_pkg::F_SLOT]};
    q_desc.block      = {field_bytes[oosf_pkg::F_BLOCK + 1], field_bytes[oosf_pkg::F_BLOCK]};
    q_desc.slot_count = field_bytes[oosf_pkg::F_COUNT];
    q_desc.sts        = field_bytes[oosf_pkg::F_STS];

    // Recognized frames of other types are dropped here
    q_push = accept && frame_end &&
             (is_probe || is_norec || msg_type_next == oosf_pkg::MSG_START);
  end

endmodule

// ===== hw/rtl/oosf_queue.sv =====
// ----------------------------------------------------------------------------
// oosf_queue
// Short queue of frame verdicts between the capture and the response side.
// ----------------------------------------------------------------------------
module oosf_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  oosf_pkg::desc_t  push_desc,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output oosf_pkg::desc_t  head
);

  oosf_pkg::desc_t                  mem [oosf_pkg::QDEPTH];
  logic [oosf_pkg::QPTR_W-1:0]      wptr;
  logic [oosf_pkg::QPTR_W-1:0]      rptr;
  logic [oosf_pkg::QCNT_W-1:0]      count;

  assign full  = (count == oosf_pkg::QCNT_W'(oosf_pkg::QDEPTH));
  assign empty = (count == '0);
  assign head  = mem[rptr];

  // Pointer wrap
  function automatic logic [oosf_pkg::QPTR_W-1:0] bump(input logic [oosf_pkg::QPTR_W-1:0] p);
    return (p == oosf_pkg::QPTR_W'(oosf_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= bump(wptr);
      end
      if (pop) begin
        rptr <= bump(rptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_desc;
    end
  end

endmodule

// ===== hw/rtl/oosf_back.sv =====
// ----------------------------------------------------------------------------
// oosf_back
// Plays out the result items of one frame verdict into an output register.
// ----------------------------------------------------------------------------
module oosf_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  oosf_pkg::desc_t    q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output oosf_pkg::result_t  out_res
);

  oosf_pkg::desc_t            desc;
  logic [23:0]                round;
  logic                       busy;
  logic [oosf_pkg::IDX_W-1:0] idx;
  oosf_pkg::result_t          res;
  logic                       emit;

  // Result item at the current burst position
  always_comb begin
    res = '0;
    unique case (desc.action)
      oosf_pkg::ACT_PROBE: begin
        res.kind      = oosf_pkg::KIND_BYTE;
        res.resp_byte = oosf_pkg::PROBE_BYTE;
        res.run_last  = 1'b1;
      end
      oosf_pkg::ACT_NOREC: begin
        res.kind     = oosf_pkg::KIND_NOREC;
        res.run_last = 1'b1;
      end
      oosf_pkg::ACT_ACK: begin
        if (idx == oosf_pkg::PARAM_IDX) begin
          res.kind           = oosf_pkg::KIND_PARAMS;
          res.run_last       = 1'b1;
          res.session_value  = desc.session;
          res.dst_addr       = desc.ctrl_addr;
          res.src_addr       = desc.ctee_addr;
          res.channel        = desc.channel;
          res.preamble       = desc.preamble;
          res.slot_time      = desc.slot;
          res.block_time     = desc.block;
          res.round_duration = round;
          res.sts_mode       = desc.sts;
        end else begin
          res.kind      = oosf_pkg::KIND_BYTE;
          res.resp_byte = oosf_pkg::ack_byte(idx, desc.status, desc.session);
          res.run_last  = (desc.status != oosf_pkg::ST_OK) && (idx == oosf_pkg::ACK_LAST);
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

  // Take the next verdict as soon as the current burst ends
  assign emit  = busy && (!out_valid || !out_stall);
  assign q_pop = !q_empty && (!busy || (emit && res.run_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (emit) begin
        busy <= !res.run_last;
        idx  <= idx + 1'b1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      desc  <= q_head;
      round <= q_head.slot * q_head.slot_count;
    end
    if (emit) begin
      out_res <= res;
    end
  end

endmodule

// ===== hw/rtl/oob_start_frame_parser.sv =====
// ----------------------------------------------------------------------------
// oob_start_frame_parser
// Out-of-band start-session frame parser: byte capture, verdict queue and
// response playout.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake              Payload
// input    in         in_valid / in_stall    rx_byte, frame_end
// output   out        out_valid / out_stall  kind, resp_byte, run_last, params
//
// One byte is taken every cycle while the verdict queue (two entries) has room.
// A frame's results leave the output register one per cycle unless out_stall is
// high, after queue and verdict register; later bursts follow with no gap.
// A long acknowledge burst fills the queue and only then stalls the input.
// Synchronous reset clears the byte counter, queue, playout state and output valid.
// ----------------------------------------------------------------------------
module oob_start_frame_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        frame_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  resp_byte,
  output logic        run_last,
  output logic [31:0] session_value,
  output logic [15:0] dst_addr,
  output logic [15:0] src_addr,
  output logic [7:0]  channel,
  output logic [7:0]  preamble,
  output logic [15:0] slot_time,
  output logic [15:0] block_time,
  output logic [23:0] round_duration,
  output logic [7:0]  sts_mode
);

  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_empty;
  oosf_pkg::desc_t    push_desc;
  oosf_pkg::desc_t    q_head;
  oosf_pkg::result_t  out_res;

  oosf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .frame_end (frame_end),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_desc    (push_desc)
  );

  oosf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_desc (push_desc),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  oosf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  // Unpack the result item
  assign kind           = out_res.kind;
  assign resp_byte      = out_res.resp_byte;
  assign run_last       = out_res.run_last;
  assign session_value  = out_res.session_value;
  assign dst_addr       = out_res.dst_addr;
  assign src_addr       = out_res.src_addr;
  assign channel        = out_res.channel;
  assign preamble       = out_res.preamble;
  assign slot_time      = out_res.slot_time;
  assign block_time     = out_res.block_time;
  assign round_duration = out_res.round_duration;
  assign sts_mode       = out_res.sts_mode;

  // Checks
  a_push_room: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("verdict pushed into a full queue");

  a_pop_data: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("verdict popped from an empty queue");

  a_params_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == oosf_pkg::KIND_PARAMS) |-> run_last)
    else $error("parameter item not marked as last of its frame");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    (q_pop && out_valid && out_stall) |=> out_valid)
    else $error("output item lost while loading the next verdict");

endmodule
